// ===== rtl/core/bfrz_pkg.sv =====
// Shared constants, field widths, command codes and controller types for the
// block feedback rotozoom step. No dependencies; every other file uses it.
`timescale 1ns / 1ps
`default_nettype none

package bfrz_pkg;

    localparam int TILE_SIZE    = 16;
    localparam int TILES_ACROSS = 23;
    localparam int TILES_DOWN   = 17;

    localparam int STORE_W = TILE_SIZE * TILES_ACROSS;
    localparam int STORE_H = TILE_SIZE * TILES_DOWN;
    localparam int STORE_N = STORE_W * STORE_H;

    localparam int X_W    = $clog2(STORE_W);
    localparam int Y_W    = $clog2(STORE_H);
    localparam int ADDR_W = $clog2(STORE_N);
    localparam int TX_W   = $clog2(TILES_ACROSS);
    localparam int TY_W   = $clog2(TILES_DOWN);
    localparam int TI_W   = $clog2(TILE_SIZE);
    // Signed width for sample coordinates before clamping.
    localparam int SC_W   = ((X_W > Y_W) ? X_W : Y_W) + 3;

    localparam int OP_W      = 2;
    localparam int SEED_W    = 4;
    localparam int COLOR_W   = 8;
    localparam int SHIFT_W   = 4;
    localparam int PIX_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 2;

    localparam logic [OP_W-1:0] OP_SEED   = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM     = 2'd1;

    typedef enum logic [3:0] {
        ST_CLEAR_GO,
        ST_CLEAR_WAIT,
        ST_IDLE,
        ST_ADDR,
        ST_SEED_WR,
        ST_READ_MEM,
        ST_COPY_GO,
        ST_COPY_WAIT,
        ST_BACK_GO,
        ST_BACK_WAIT,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SCAN_CLEAR,
        SCAN_COPY,
        SCAN_BACK
    } scan_mode_t;

    typedef struct packed {
        logic load;
        logic addr;
        logic seed_wr;
        logic read;
        logic start_clear;
        logic start_copy;
        logic start_back;
        logic result;
    } dp_cmd_t;

    typedef struct packed {
        logic            scan_busy;
        logic [OP_W-1:0] op;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bfrz_ctrl.sv =====
// Controller state machine for the rotozoom step: sequences item handling,
// store passes and the result register. Depends on bfrz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfrz_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire logic [bfrz_pkg::OP_W-1:0]  operation,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output bfrz_pkg::dp_cmd_t               cmd,
    input  wire bfrz_pkg::dp_status_t       status
);

    bfrz_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfrz_pkg::ST_CLEAR_GO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            bfrz_pkg::ST_CLEAR_GO:
            begin
                cmd.start_clear = 1'b1;
                state_next      = bfrz_pkg::ST_CLEAR_WAIT;
            end
            bfrz_pkg::ST_CLEAR_WAIT:
            begin
                if (!status.scan_busy)
                    state_next = bfrz_pkg::ST_IDLE;
            end
            bfrz_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (operation) inside
                        bfrz_pkg::OP_SEED, bfrz_pkg::OP_READ:
                            state_next = bfrz_pkg::ST_ADDR;
                        bfrz_pkg::OP_STEP:
                            state_next = bfrz_pkg::ST_COPY_GO;
                        default:
                            state_next = bfrz_pkg::ST_FINISH;
                    endcase
                end
            end
            bfrz_pkg::ST_ADDR:
            begin
                cmd.addr = 1'b1;
                if (status.op == bfrz_pkg::OP_SEED)
                    state_next = bfrz_pkg::ST_SEED_WR;
                else
                    state_next = bfrz_pkg::ST_READ_MEM;
            end
            bfrz_pkg::ST_SEED_WR:
            begin
                cmd.seed_wr = 1'b1;
                state_next  = bfrz_pkg::ST_FINISH;
            end
            bfrz_pkg::ST_READ_MEM:
            begin
                cmd.read   = 1'b1;
                state_next = bfrz_pkg::ST_FINISH;
            end
            bfrz_pkg::ST_COPY_GO:
            begin
                cmd.start_copy = 1'b1;
                state_next     = bfrz_pkg::ST_COPY_WAIT;
            end
            bfrz_pkg::ST_COPY_WAIT:
            begin
                // The tile store must be complete before the write-back reads it.
                if (!status.scan_busy)
                    state_next = bfrz_pkg::ST_BACK_GO;
            end
            bfrz_pkg::ST_BACK_GO:
            begin
                cmd.start_back = 1'b1;
                state_next     = bfrz_pkg::ST_BACK_WAIT;
            end
            bfrz_pkg::ST_BACK_WAIT:
            begin
                if (!status.scan_busy)
                    state_next = bfrz_pkg::ST_FINISH;
            end
            bfrz_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.result = 1'b1;
                    state_next = bfrz_pkg::ST_IDLE;
                end
            end
            default:
                state_next = bfrz_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.result)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign item_ready   = (state_reg == bfrz_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bfrz_datapath.sv =====
// Datapath for the rotozoom step: frame and tile memories, scan counters,
// sampling pipeline, item registers and result payload. Depends on bfrz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfrz_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic [bfrz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bfrz_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic [bfrz_pkg::OP_W-1:0]         operation,
    input  wire logic [bfrz_pkg::SEED_W-1:0]       seed_dx,
    input  wire logic [bfrz_pkg::SEED_W-1:0]       seed_dy,
    input  wire logic [bfrz_pkg::COLOR_W-1:0]      seed_color,
    input  wire logic [bfrz_pkg::SHIFT_W-1:0]      shift,
    input  wire logic [bfrz_pkg::PIX_W-1:0]        pixel_x,
    input  wire logic [bfrz_pkg::PIX_W-1:0]        pixel_y,
    input  wire bfrz_pkg::dp_cmd_t                 cmd,
    output bfrz_pkg::dp_status_t                   status,
    output logic [bfrz_pkg::COLOR_W-1:0]           pixel_value,
    output logic [bfrz_pkg::OP_W-1:0]              finished_operation
);

    localparam int X_W    = bfrz_pkg::X_W;
    localparam int Y_W    = bfrz_pkg::Y_W;
    localparam int ADDR_W = bfrz_pkg::ADDR_W;
    localparam int TX_W   = bfrz_pkg::TX_W;
    localparam int TY_W   = bfrz_pkg::TY_W;
    localparam int TI_W   = bfrz_pkg::TI_W;
    localparam int SC_W   = bfrz_pkg::SC_W;
    localparam int C_W    = bfrz_pkg::COLOR_W;
    localparam int SH_W   = bfrz_pkg::SHIFT_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(bfrz_pkg::STORE_N - 1);
    localparam logic [X_W-1:0]    X_LAST    = X_W'(bfrz_pkg::STORE_W - 1);
    localparam logic [Y_W-1:0]    Y_LAST    = Y_W'(bfrz_pkg::STORE_H - 1);
    localparam logic [TI_W-1:0]   TI_LAST   = TI_W'(bfrz_pkg::TILE_SIZE - 1);
    localparam logic signed [SC_W-1:0] X_MAX_S = SC_W'(bfrz_pkg::STORE_W - 1);
    localparam logic signed [SC_W-1:0] Y_MAX_S = SC_W'(bfrz_pkg::STORE_H - 1);

    // Configuration registers.
    logic signed [bfrz_pkg::CFG_W-1:0] rot_reg, zoom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg  <= 2'sb01;
            zoom_reg <= 2'sb11;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == bfrz_pkg::CFG_ROTATION)
                rot_reg <= $signed(cfg_data);
            else if (cfg_index == bfrz_pkg::CFG_ZOOM)
                zoom_reg <= $signed(cfg_data);
        end
    end

    // Item registers.
    logic [bfrz_pkg::OP_W-1:0]  op_reg;
    logic [bfrz_pkg::SEED_W-1:0] seed_dx_reg, seed_dy_reg;
    logic [C_W-1:0]             color_reg;
    logic [SH_W-1:0]            s_reg, s_next;
    logic [bfrz_pkg::PIX_W-1:0] pixel_x_reg, pixel_y_reg;
    logic [ADDR_W-1:0]          item_addr_reg, item_addr_next;
    logic                       item_ok_reg, item_ok_next;
    logic [ADDR_W-1:0]          back_off_reg;
    logic [Y_W-1:0]             item_row;
    logic [X_W-1:0]             item_col;

    // A shift of a whole tile or more saturates to the last in-tile offset.
    always_comb
    begin
        if (int'(shift) > bfrz_pkg::TILE_SIZE - 1)
            s_next = SH_W'(bfrz_pkg::TILE_SIZE - 1);
        else
            s_next = shift;
    end

    always_comb
    begin
        if (op_reg == bfrz_pkg::OP_READ)
        begin
            item_row     = Y_W'(pixel_y_reg);
            item_col     = X_W'(pixel_x_reg);
            item_ok_next = (int'(pixel_x_reg) < bfrz_pkg::STORE_W) &&
                           (int'(pixel_y_reg) < bfrz_pkg::STORE_H);
        end
        else
        begin
            item_row     = Y_W'(bfrz_pkg::STORE_H / 2) + Y_W'(seed_dy_reg);
            item_col     = X_W'(bfrz_pkg::STORE_W / 2) + X_W'(seed_dx_reg);
            item_ok_next = (int'(seed_dx_reg) <= bfrz_pkg::TILE_SIZE / 2) &&
                           (int'(seed_dy_reg) <= bfrz_pkg::TILE_SIZE / 2);
        end
        item_addr_next = ADDR_W'(ADDR_W'(item_row) * ADDR_W'(bfrz_pkg::STORE_W))
                         + ADDR_W'(item_col);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            seed_dx_reg <= seed_dx;
            seed_dy_reg <= seed_dy;
            color_reg   <= seed_color;
            s_reg       <= s_next;
            pixel_x_reg <= pixel_x;
            pixel_y_reg <= pixel_y;
        end
        if (cmd.addr)
        begin
            item_addr_reg <= item_addr_next;
            item_ok_reg   <= item_ok_next;
        end
        // Write-back destination is the source moved by shift rows and columns.
        if (cmd.start_copy)
            back_off_reg <= ADDR_W'(ADDR_W'(s_reg) * ADDR_W'(bfrz_pkg::STORE_W + 1));
    end

    // Scan counters.
    logic                 active_reg, active_next;
    bfrz_pkg::scan_mode_t mode_reg, mode_next;
    logic [ADDR_W-1:0]    lin_reg, lin_next;
    logic [X_W-1:0]       dx_reg, dx_next;
    logic [Y_W-1:0]       dy_reg, dy_next;
    logic [TI_W-1:0]      xi_reg, xi_next, yi_reg, yi_next;
    logic [TX_W-1:0]      tx_reg, tx_next;
    logic [TY_W-1:0]      ty_reg, ty_next;
    logic [X_W-1:0]       bcol_reg, bcol_next, bcol_last;
    logic [Y_W-1:0]       brow_reg, brow_next, brow_last;
    logic [ADDR_W-1:0]    bsrc_reg, bsrc_next;

    assign bcol_last = X_LAST - X_W'(s_reg);
    assign brow_last = Y_LAST - Y_W'(s_reg);

    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        lin_next    = lin_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        xi_next     = xi_reg;
        yi_next     = yi_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        bcol_next   = bcol_reg;
        brow_next   = brow_reg;
        bsrc_next   = bsrc_reg;
        if (cmd.start_clear)
        begin
            active_next = 1'b1;
            mode_next   = bfrz_pkg::SCAN_CLEAR;
            lin_next    = '0;
        end
        else if (cmd.start_copy)
        begin
            active_next = 1'b1;
            mode_next   = bfrz_pkg::SCAN_COPY;
            lin_next    = '0;
            dx_next     = '0;
            dy_next     = '0;
            xi_next     = '0;
            yi_next     = '0;
            tx_next     = '0;
            ty_next     = '0;
        end
        else if (cmd.start_back)
        begin
            active_next = 1'b1;
            mode_next   = bfrz_pkg::SCAN_BACK;
            bcol_next   = '0;
            brow_next   = '0;
            bsrc_next   = '0;
        end
        else if (active_reg)
        begin
            unique case (mode_reg)
                bfrz_pkg::SCAN_CLEAR:
                begin
                    lin_next = lin_reg + 1'b1;
                    if (lin_reg == LAST_ADDR)
                        active_next = 1'b0;
                end
                bfrz_pkg::SCAN_COPY:
                begin
                    lin_next = lin_reg + 1'b1;
                    if (lin_reg == LAST_ADDR)
                        active_next = 1'b0;
                    if (dx_reg == X_LAST)
                    begin
                        dx_next = '0;
                        xi_next = '0;
                        tx_next = '0;
                        dy_next = dy_reg + 1'b1;
                        if (yi_reg == TI_LAST)
                        begin
                            yi_next = '0;
                            ty_next = ty_reg + 1'b1;
                        end
                        else
                            yi_next = yi_reg + 1'b1;
                    end
                    else
                    begin
                        dx_next = dx_reg + 1'b1;
                        if (xi_reg == TI_LAST)
                        begin
                            xi_next = '0;
                            tx_next = tx_reg + 1'b1;
                        end
                        else
                            xi_next = xi_reg + 1'b1;
                    end
                end
                bfrz_pkg::SCAN_BACK:
                begin
                    if (bcol_reg == bcol_last)
                    begin
                        bcol_next = '0;
                        // Skip the columns that fall off the right edge.
                        bsrc_next = bsrc_reg + ADDR_W'(s_reg) + 1'b1;
                        if (brow_reg == brow_last)
                            active_next = 1'b0;
                        else
                            brow_next = brow_reg + 1'b1;
                    end
                    else
                    begin
                        bcol_next = bcol_reg + 1'b1;
                        bsrc_next = bsrc_reg + 1'b1;
                    end
                end
                default:
                    active_next = 1'b0;
            endcase
        end
    end

    logic clear_wr, copy_issue, back_issue;
    assign clear_wr   = active_reg && (mode_reg == bfrz_pkg::SCAN_CLEAR);
    assign copy_issue = active_reg && (mode_reg == bfrz_pkg::SCAN_COPY);
    assign back_issue = active_reg && (mode_reg == bfrz_pkg::SCAN_BACK);

    // Sample coordinates of the current pixel, clamped to the store.
    logic signed [SC_W-1:0] u_s, v_s, zoom_s, rot_s, dx_s, dy_s, s_s;
    logic signed [SC_W-1:0] zu_s, zv_s, ru_s, rv_s, sx_raw, sy_raw;
    logic [X_W-1:0]         sx_next;
    logic [Y_W-1:0]         sy_next;

    assign u_s    = $signed(SC_W'(tx_reg)) - $signed(SC_W'(bfrz_pkg::TILES_ACROSS / 2));
    assign v_s    = $signed(SC_W'(ty_reg)) - $signed(SC_W'(bfrz_pkg::TILES_DOWN / 2));
    assign zoom_s = SC_W'(zoom_reg);
    assign rot_s  = SC_W'(rot_reg);
    assign dx_s   = $signed(SC_W'(dx_reg));
    assign dy_s   = $signed(SC_W'(dy_reg));
    assign s_s    = $signed(SC_W'(s_reg));
    assign zu_s   = zoom_s * u_s;
    assign zv_s   = zoom_s * v_s;
    assign ru_s   = rot_s * u_s;
    assign rv_s   = rot_s * v_s;
    assign sx_raw = dx_s + s_s + zu_s - rv_s;
    assign sy_raw = dy_s + s_s + zv_s + ru_s;

    always_comb
    begin
        if (sx_raw < 0)
            sx_next = '0;
        else if (sx_raw > X_MAX_S)
            sx_next = X_LAST;
        else
            sx_next = sx_raw[X_W-1:0];
        if (sy_raw < 0)
            sy_next = '0;
        else if (sy_raw > Y_MAX_S)
            sy_next = Y_LAST;
        else
            sy_next = sy_raw[Y_W-1:0];
    end

    // Copy pipeline: clamp, address, frame read, tile write.
    logic              c1_v_reg, c2_v_reg, c3_v_reg, b1_v_reg;
    logic [X_W-1:0]    c1_sx_reg;
    logic [Y_W-1:0]    c1_sy_reg;
    logic [ADDR_W-1:0] c1_dst_reg, c2_src_reg, c2_dst_reg, c3_dst_reg, b1_dst_reg;
    logic [ADDR_W-1:0] c2_src_next;

    assign c2_src_next = ADDR_W'(ADDR_W'(c1_sy_reg) * ADDR_W'(bfrz_pkg::STORE_W))
                         + ADDR_W'(c1_sx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            mode_reg   <= bfrz_pkg::SCAN_CLEAR;
            c1_v_reg   <= 1'b0;
            c2_v_reg   <= 1'b0;
            c3_v_reg   <= 1'b0;
            b1_v_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            mode_reg   <= mode_next;
            c1_v_reg   <= copy_issue;
            c2_v_reg   <= c1_v_reg;
            c3_v_reg   <= c2_v_reg;
            b1_v_reg   <= back_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg    <= lin_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        xi_reg     <= xi_next;
        yi_reg     <= yi_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        bcol_reg   <= bcol_next;
        brow_reg   <= brow_next;
        bsrc_reg   <= bsrc_next;
        c1_sx_reg  <= sx_next;
        c1_sy_reg  <= sy_next;
        c1_dst_reg <= lin_reg;
        c2_src_reg <= c2_src_next;
        c2_dst_reg <= c1_dst_reg;
        c3_dst_reg <= c2_dst_reg;
        b1_dst_reg <= bsrc_reg + back_off_reg;
    end

    // Frame store ports.
    logic              fw_en, fr_en;
    logic [ADDR_W-1:0] fw_addr, fr_addr;
    logic [C_W-1:0]    fw_data;
    logic [C_W-1:0]    frame_rd_reg, tile_rd_reg;

    always_comb
    begin
        fw_en   = 1'b0;
        fw_addr = item_addr_reg;
        fw_data = color_reg;
        if (clear_wr)
        begin
            fw_en   = 1'b1;
            fw_addr = lin_reg;
            fw_data = '0;
        end
        else if (b1_v_reg)
        begin
            fw_en   = 1'b1;
            fw_addr = b1_dst_reg;
            fw_data = tile_rd_reg;
        end
        else if (cmd.seed_wr && item_ok_reg)
            fw_en = 1'b1;
    end

    assign fr_en   = c2_v_reg || cmd.read;
    assign fr_addr = c2_v_reg ? c2_src_reg : item_addr_reg;

    logic [C_W-1:0] frame_mem [bfrz_pkg::STORE_N];
    logic [C_W-1:0] tile_mem  [bfrz_pkg::STORE_N];

    always_ff @(posedge clk)
    begin
        if (fw_en)
            frame_mem[fw_addr] <= fw_data;
        if (fr_en)
            frame_rd_reg <= frame_mem[fr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (c3_v_reg)
            tile_mem[c3_dst_reg] <= frame_rd_reg;
        if (back_issue)
            tile_rd_reg <= tile_mem[bsrc_reg];
    end

    // Result payload.
    logic [C_W-1:0]            pix_out_reg;
    logic [bfrz_pkg::OP_W-1:0] fin_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            if (op_reg == bfrz_pkg::OP_READ && item_ok_reg)
                pix_out_reg <= frame_rd_reg;
            else
                pix_out_reg <= '0;
            fin_out_reg <= op_reg;
        end
    end

    assign pixel_value        = pix_out_reg;
    assign finished_operation = fin_out_reg;

    assign status.scan_busy = active_reg || c1_v_reg || c2_v_reg || c3_v_reg || b1_v_reg;
    assign status.op        = op_reg;

endmodule

`default_nettype wire

// ===== rtl/core/block_feedback_rotozoom_step.sv =====
// Seed and read codes pass the address and memory states; unused codes skip them.
// Step: two store passes driven by the scan counters, one pixel per cycle each:
// the tile copy covers all STORE_N pixels, the write-back (H-s)*(W-s) of them.
// One item is in work at a time; the frame and tile memory ports set the rate.
// After reset a clearing pass zeroes all STORE_N (100096) words of the frame store
// with item_ready low; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module block_feedback_rotozoom_step (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bfrz_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bfrz_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [bfrz_pkg::OP_W-1:0]         operation,
    input  wire logic [bfrz_pkg::SEED_W-1:0]       seed_dx,
    input  wire logic [bfrz_pkg::SEED_W-1:0]       seed_dy,
    input  wire logic [bfrz_pkg::COLOR_W-1:0]      seed_color,
    input  wire logic [bfrz_pkg::SHIFT_W-1:0]      shift,
    input  wire logic [bfrz_pkg::PIX_W-1:0]        pixel_x,
    input  wire logic [bfrz_pkg::PIX_W-1:0]        pixel_y,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [bfrz_pkg::COLOR_W-1:0]           pixel_value,
    output logic [bfrz_pkg::OP_W-1:0]              finished_operation
);

    bfrz_pkg::dp_cmd_t    cmd;
    bfrz_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    bfrz_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    bfrz_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .operation          (operation),
        .seed_dx            (seed_dx),
        .seed_dy            (seed_dy),
        .seed_color         (seed_color),
        .shift              (shift),
        .pixel_x            (pixel_x),
        .pixel_y            (pixel_y),
        .cmd                (cmd),
        .status             (status),
        .pixel_value        (pixel_value),
        .finished_operation (finished_operation)
    );

endmodule

`default_nettype wire

// ===== rtl/core/bfrz_checker.sv =====
// Port-level checks for block_feedback_rotozoom_step, attached by bind.
// Depends on bfrz_pkg and the top-level port list.
`timescale 1ns / 1ps
`default_nettype none

module bfrz_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              item_valid,
    input wire logic                              item_ready,
    input wire logic [bfrz_pkg::OP_W-1:0]         operation,
    input wire logic                              result_valid,
    input wire logic                              result_ready,
    input wire logic [bfrz_pkg::COLOR_W-1:0]      pixel_value,
    input wire logic [bfrz_pkg::OP_W-1:0]         finished_operation
);

    // A stalled result keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(pixel_value) && $stable(finished_operation))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while another is in work");

    // Only read items carry a pixel value.
    a_zero_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (finished_operation != bfrz_pkg::OP_READ) |-> pixel_value == '0)
        else $error("nonzero pixel value on a result that is not a read");

    // An unused operation code passes only the finish state before its result is valid.
    a_unused_code: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (operation == bfrz_pkg::OP_UNUSED) && !result_valid |->
            ##2 result_valid && (finished_operation == bfrz_pkg::OP_UNUSED))
        else $error("unused operation code did not finish in time");

endmodule

bind block_feedback_rotozoom_step bfrz_checker u_bfrz_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item_valid),
    .item_ready         (item_ready),
    .operation          (operation),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .pixel_value        (pixel_value),
    .finished_operation (finished_operation)
);

`default_nettype wire
